@@ hdl/lle_pkg.sv @@
// ----------------------------------------------------------------------------
// lle_pkg: shared types and constants of the linked list engine
// opcodes, status codes, sequencer states and the pool defaults
// ----------------------------------------------------------------------------
package lle_pkg;

  localparam int unsigned DefCapacity  = 64;
  localparam int unsigned DefDataWidth = 32;
  localparam int unsigned OpWidth      = 3;
  localparam int unsigned PosWidth     = 7;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned OutWidth     = 32;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_DELETE     = 3'd5,
    OP_READ_AT    = 3'd6,
    OP_READ_BACK  = 3'd7
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,     // free chain build after reset
    S_IDLE,
    S_DECIDE,   // free head link and tail data reads are back
    S_WALK,     // follow one link per cycle
    S_STEP2,    // second dependent read
    S_STEP3,    // third dependent read
    S_DONE
  } state_e;

endpackage

@@ hdl/linked_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// linked_list_engine_unit: bounded singly linked list over a slot pool
// sequencer around a link memory and a data memory
// ----------------------------------------------------------------------------
//  channel   signals                               direction
//  request   start_i, busy_o, op_i, position_i,    in
//            data_in_i
//  result    done_o, status_o, data_valid_o,       out
//            data_out_o, length_o
//
// A request holds busy_o from S_DECIDE through any S_WALK, S_STEP2 and
// S_STEP3 steps to S_DONE; index requests and pop back walk up to
// CAPACITY - 1 links through the link memory read port.
// done_o rises in the same cycle as busy_o falls, when a new request may
// already be accepted. After reset the free chain is built one slot per
// cycle with busy_o high. done_o is high for one cycle;
// the receiver cannot stall.
// ----------------------------------------------------------------------------
module linked_list_engine_unit #(
  parameter int unsigned CAPACITY   = lle_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = lle_pkg::DefDataWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [lle_pkg::OpWidth-1:0]        op_i,
  input  logic [lle_pkg::PosWidth-1:0]       position_i,
  input  logic [lle_pkg::OutWidth-1:0]       data_in_i,
  output logic                               done_o,
  output logic [lle_pkg::StatusWidth-1:0]    status_o,
  output logic                               data_valid_o,
  output logic [lle_pkg::OutWidth-1:0]       data_out_o,
  output logic [lle_pkg::PosWidth-1:0]       length_o
);

  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned PosW  = lle_pkg::PosWidth;
  localparam int unsigned OutW  = lle_pkg::OutWidth;
  // the walk counter must cover both the position field and the count
  localparam int unsigned WalkW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // state registers
  lle_pkg::state_e          state_q, state_d;
  logic [SlotW-1:0]         head_q, head_d, tail_q, tail_d, free_q, free_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [SlotW-1:0]         init_q, init_d;
  lle_pkg::op_e             op_q, op_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic [DATA_WIDTH-1:0]    word_q, word_d;
  logic [WalkW-1:0]         walk_q, walk_d;
  logic [SlotW-1:0]         cur_q, cur_d;   // slot whose link is being read
  logic [SlotW-1:0]         aux_q, aux_d;   // second slot of a request
  logic                     done_q, done_d;
  logic [lle_pkg::StatusWidth-1:0] st_q, st_d;
  logic                     dv_q, dv_d;
  logic [DATA_WIDTH-1:0]    dout_q, dout_d;

  // memory ports
  logic                     lwe, dwe;
  logic [SlotW-1:0]         lwa, lwd, lra, lrd, dwa, dra;
  logic [DATA_WIDTH-1:0]    dwd, drd;

  lle_link_mem #(.Capacity(CAPACITY)) u_link (
    .clk_i, .we_i(lwe), .waddr_i(lwa), .wdata_i(lwd), .raddr_i(lra), .rdata_o(lrd)
  );

  lle_data_mem #(.Capacity(CAPACITY), .DataWidth(DATA_WIDTH)) u_data (
    .clk_i, .we_i(dwe), .waddr_i(dwa), .wdata_i(dwd), .raddr_i(dra), .rdata_o(drd)
  );

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != lle_pkg::S_IDLE);

  // control and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lle_pkg::S_INIT;
      head_q  <= '0;
      tail_q  <= '0;
      free_q  <= '0;
      cnt_q   <= '0;
      init_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      cnt_q   <= cnt_d;
      init_q  <= init_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    pos_q  <= pos_d;
    word_q <= word_d;
    walk_q <= walk_d;
    cur_q  <= cur_d;
    aux_q  <= aux_d;
    st_q   <= st_d;
    dv_q   <= dv_d;
    dout_q <= dout_d;
  end

  // helpers on the latched request
  logic [WalkW-1:0] pos_w, cnt_w;
  logic             full, empty;
  assign pos_w = WalkW'(pos_q);
  assign cnt_w = WalkW'(cnt_q);
  assign full  = (cnt_q == CapCnt);
  assign empty = (cnt_q == '0);

  // sequencer
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    free_d  = free_q;
    cnt_d   = cnt_q;
    init_d  = init_q;
    op_d    = op_q;
    pos_d   = pos_q;
    word_d  = word_q;
    walk_d  = walk_q;
    cur_d   = cur_q;
    aux_d   = aux_q;
    done_d  = 1'b0;
    st_d    = st_q;
    dv_d    = dv_q;
    dout_d  = dout_q;
    lwe = 1'b0; lwa = cur_q; lwd = '0; lra = cur_q;
    dwe = 1'b0; dwa = free_q; dwd = word_q; dra = tail_q;

    unique case (state_q)
      lle_pkg::S_INIT: begin
        // chain slot i to i+1, last wraps to 0
        lwe = 1'b1;
        lwa = init_q;
        lwd = init_q + SlotW'(1);
        init_d = init_q + SlotW'(1);
        if (init_q == SlotW'(CAPACITY - 1)) begin
          state_d = lle_pkg::S_IDLE;
        end
      end

      lle_pkg::S_IDLE: begin
        if (accept) begin
          op_d   = lle_pkg::op_e'(op_i);
          if (op_i == lle_pkg::OP_INSERT && position_i == '0) begin
            op_d = lle_pkg::OP_PUSH_FRONT;
          end
          pos_d  = position_i;
          word_d = DATA_WIDTH'(data_in_i);
          st_d   = lle_pkg::ST_OK;
          dv_d   = 1'b0;
          dout_d = '0;
          // fetch free head link and tail data
          lra = free_q;
          dra = tail_q;
          cur_d = head_q;
          state_d = lle_pkg::S_DECIDE;
        end
      end

      lle_pkg::S_DECIDE: begin
        // lrd = next_links[free_q], drd = slot_data[tail_q]
        state_d = lle_pkg::S_DONE;
        unique case (op_q) inside
          lle_pkg::OP_PUSH_FRONT, lle_pkg::OP_PUSH_BACK: begin
            if (full) begin
              st_d = lle_pkg::ST_FULL;
            end else begin
              dwe = 1'b1;
              dwa = free_q;
              free_d = lrd;
              if (op_q == lle_pkg::OP_PUSH_FRONT) begin
                lwe = 1'b1; lwa = free_q; lwd = head_q;
                head_d = free_q;
                if (empty) tail_d = free_q;
              end else begin
                if (empty) head_d = free_q;
                else begin
                  lwe = 1'b1; lwa = tail_q; lwd = free_q;
                end
                tail_d = free_q;
              end
              cnt_d = cnt_q + CntW'(1);
            end
          end
          lle_pkg::OP_READ_BACK: begin
            if (empty) st_d = lle_pkg::ST_EMPTY;
            else begin
              dv_d = 1'b1; dout_d = drd;
            end
          end
          lle_pkg::OP_POP_FRONT, lle_pkg::OP_POP_BACK: begin
            if (empty) st_d = lle_pkg::ST_EMPTY;
            else if (op_q == lle_pkg::OP_POP_BACK) begin
              dv_d = 1'b1; dout_d = drd;
              // give tail slot back
              lwe = 1'b1; lwa = tail_q; lwd = free_q;
              free_d = tail_q;
              cnt_d = cnt_q - CntW'(1);
              if (cnt_q >= CntW'(2)) begin
                walk_d = cnt_w - WalkW'(2);
                cur_d = head_q;
                lra = head_q;
                aux_d = '0;
                state_d = (cnt_q == CntW'(2)) ? lle_pkg::S_DONE : lle_pkg::S_WALK;
                if (cnt_q == CntW'(2)) tail_d = head_q;
              end
            end else begin
              // read head link and head data
              lra = head_q;
              dra = head_q;
              state_d = lle_pkg::S_STEP2;
            end
          end
          lle_pkg::OP_INSERT: begin
            if (pos_w > cnt_w) st_d = lle_pkg::ST_EMPTY;
            else if (full) st_d = lle_pkg::ST_FULL;
            else begin
              aux_d = lrd;   // new free head after allocation
              walk_d = pos_w - WalkW'(1);
              cur_d = head_q;
              lra = head_q;
              state_d = (pos_w == WalkW'(1)) ? lle_pkg::S_STEP2 : lle_pkg::S_WALK;
            end
          end
          lle_pkg::OP_DELETE, lle_pkg::OP_READ_AT: begin
            if (pos_w >= cnt_w) st_d = lle_pkg::ST_EMPTY;
            else if (op_q == lle_pkg::OP_DELETE && pos_w == '0) begin
              lra = head_q;
              state_d = lle_pkg::S_STEP2;
            end else begin
              walk_d = (op_q == lle_pkg::OP_READ_AT) ? pos_w : pos_w - WalkW'(1);
              cur_d = head_q;
              lra = head_q;
              dra = head_q;
              state_d = (walk_d == '0) ? lle_pkg::S_STEP2 : lle_pkg::S_WALK;
            end
          end
          default: ;
        endcase
      end

      lle_pkg::S_WALK: begin
        // lrd = next_links[cur_q]; one link per cycle
        cur_d  = lrd;
        lra    = lrd;
        dra    = lrd;
        walk_d = walk_q - WalkW'(1);
        if (walk_q == WalkW'(1)) begin
          if (op_q == lle_pkg::OP_POP_BACK) begin
            tail_d = lrd;
            state_d = lle_pkg::S_DONE;
          end else begin
            state_d = lle_pkg::S_STEP2;
          end
        end
      end

      lle_pkg::S_STEP2: begin
        // cur_q is the target slot; lrd = its link, drd = its data
        state_d = lle_pkg::S_DONE;
        unique case (op_q)
          lle_pkg::OP_READ_AT: begin
            dv_d = 1'b1; dout_d = drd;
          end
          lle_pkg::OP_POP_FRONT: begin
            dv_d = 1'b1; dout_d = drd;
            head_d = lrd;
            lwe = 1'b1; lwa = head_q; lwd = free_q;
            free_d = head_q;
            cnt_d = cnt_q - CntW'(1);
          end
          lle_pkg::OP_INSERT: begin
            // cur_q is predecessor p, lrd its old link
            dwe = 1'b1; dwa = free_q;
            lwe = 1'b1; lwa = free_q; lwd = lrd;
            aux_d = free_q;
            free_d = aux_q;
            if (pos_w == cnt_w) tail_d = free_q;
            cnt_d = cnt_q + CntW'(1);
            state_d = lle_pkg::S_STEP3;
          end
          lle_pkg::OP_DELETE: begin
            if (pos_w == '0) begin
              // lrd = link of head; free head slot
              head_d = lrd;
              lwe = 1'b1; lwa = head_q; lwd = free_q;
              free_d = head_q;
              cnt_d = cnt_q - CntW'(1);
              if (cnt_q > CntW'(1)) begin
                dra = lrd;
                state_d = lle_pkg::S_STEP3;
              end
            end else begin
              // cur_q = p, lrd = nd; read link of nd
              aux_d = lrd;
              lra = lrd;
              state_d = lle_pkg::S_STEP3;
            end
          end
          default: ;
        endcase
      end

      lle_pkg::S_STEP3: begin
        state_d = lle_pkg::S_DONE;
        unique case (op_q)
          lle_pkg::OP_INSERT: begin
            // link predecessor to new slot
            lwe = 1'b1; lwa = cur_q; lwd = aux_q;
          end
          lle_pkg::OP_DELETE: begin
            if (pos_w == '0) begin
              dv_d = 1'b1; dout_d = drd;
            end else begin
              // lrd = link of nd
              lwe = 1'b1; lwa = cur_q; lwd = lrd;
              if (pos_w == cnt_w - WalkW'(1)) tail_d = cur_q;
              cnt_d = cnt_q - CntW'(1);
              if (pos_w < cnt_w - WalkW'(1)) begin
                dra = lrd;
                aux_d = lrd;
                dv_d = 1'b1;
              end
              // freed slot goes to the free chain in done
              walk_d = WalkW'(aux_q);
            end
          end
          default: ;
        endcase
      end

      lle_pkg::S_DONE: begin
        // finish delete at middle: free nd and capture following word
        if (op_q == lle_pkg::OP_DELETE && pos_w != '0 && st_q == lle_pkg::ST_OK) begin
          lwe = 1'b1; lwa = SlotW'(walk_q); lwd = free_q;
          free_d = SlotW'(walk_q);
          if (dv_q) dout_d = drd;
        end
        done_d = 1'b1;
        state_d = lle_pkg::S_IDLE;
      end

      default: state_d = lle_pkg::S_IDLE;
    endcase
  end

  // result ports
  assign done_o       = done_q;
  assign status_o     = st_q;
  assign data_valid_o = dv_q;
  assign data_out_o   = dv_q ? OutW'(dout_q) : '0;
  assign length_o     = PosW'(cnt_q);

endmodule

@@ hdl/lle_link_mem.sv @@
// ----------------------------------------------------------------------------
// lle_link_mem: link store of the slot pool
// one write port and one registered read port
// ----------------------------------------------------------------------------
module lle_link_mem #(
  parameter int unsigned Capacity = lle_pkg::DefCapacity,
  localparam int unsigned SlotW = $clog2(Capacity)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SlotW-1:0] waddr_i,
  input  logic [SlotW-1:0] wdata_i,
  input  logic [SlotW-1:0] raddr_i,
  output logic [SlotW-1:0] rdata_o
);

  logic [SlotW-1:0] mem [Capacity];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/lle_data_mem.sv @@
// ----------------------------------------------------------------------------
// lle_data_mem: data word store of the slot pool
// one write port and one registered read port
// ----------------------------------------------------------------------------
module lle_data_mem #(
  parameter int unsigned Capacity  = lle_pkg::DefCapacity,
  parameter int unsigned DataWidth = lle_pkg::DefDataWidth,
  localparam int unsigned SlotW = $clog2(Capacity)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [SlotW-1:0]     waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  input  logic [SlotW-1:0]     raddr_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem [Capacity];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/lle_checker.sv @@
// ----------------------------------------------------------------------------
// lle_checker: port level checks of the linked list engine
// bound to the top level
// ----------------------------------------------------------------------------
module lle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic       data_valid_o,
  input logic [6:0] length_o
);

  // a request makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("request not taken");

  // a result ends the busy phase
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy during result");

  // no valid word with a failing status
  a_dv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && data_valid_o |-> status_o == 2'd0) else $error("word on error");

  // length holds while idle
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !$past(done_o) && $past(!busy_o) |-> $stable(length_o))
    else $error("length changed while idle");

endmodule

bind linked_list_engine_unit lle_checker u_lle_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .status_o, .data_valid_o, .length_o
);

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: linked list engine testbench
// drives list requests, predicts each result with a slot pool model
// and checks status, data and length of every done strobe in order
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = lle_pkg::DefCapacity;

  typedef struct {
    lle_pkg::op_e op;
    logic [6:0]   pos;
    logic [31:0]  word;
  } list_req_t;

  typedef struct {
    lle_pkg::status_e status;
    logic             valid;
    logic [31:0]      dout;
    logic [6:0]       len;
  } list_resp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  op_i;
  logic [6:0]  position_i;
  logic [31:0] data_in_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic        data_valid_o;
  logic [31:0] data_out_o;
  logic [6:0]  length_o;

  linked_list_engine_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .position_i, .data_in_i,
    .done_o, .status_o, .data_valid_o, .data_out_o, .length_o
  );

  // shadow list state
  logic [31:0] pool_word [Cap];
  logic [5:0]  pool_link [Cap];
  logic [5:0]  head_q, tail_q, free_q;
  int unsigned count_q;

  list_req_t  pending_reqs[$];
  list_resp_t expected_resps[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned sent;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [5:0] slot_at(int unsigned n);
    logic [5:0] s;
    s = head_q;
    for (int unsigned i = 0; i < n && i < Cap; i++) s = pool_link[s];
    return s;
  endfunction

  function automatic logic [5:0] alloc_slot(logic [31:0] w);
    logic [5:0] s;
    s = free_q;
    free_q = pool_link[s];
    pool_word[s] = w;
    return s;
  endfunction

  function automatic void free_slot(logic [5:0] s);
    pool_link[s] = free_q;
    free_q = s;
  endfunction

  // compute the result of one request and advance the shadow list
  function automatic list_resp_t predict_list_op(list_req_t r);
    list_resp_t   res;
    lle_pkg::op_e op;
    logic [5:0]   s, p, nd;
    bit           full;
    int unsigned  pos;
    res.status = lle_pkg::ST_OK;
    res.valid = 1'b0;
    res.dout = '0;
    op = r.op;
    pos = r.pos;
    full = count_q >= Cap;
    if (op == lle_pkg::OP_INSERT && pos == 0) op = lle_pkg::OP_PUSH_FRONT;
    case (op)
      lle_pkg::OP_PUSH_FRONT: begin
        if (full) res.status = lle_pkg::ST_FULL;
        else begin
          s = alloc_slot(r.word);
          pool_link[s] = head_q;
          if (count_q == 0) tail_q = s;
          head_q = s;
          count_q++;
        end
      end
      lle_pkg::OP_PUSH_BACK: begin
        if (full) res.status = lle_pkg::ST_FULL;
        else begin
          s = alloc_slot(r.word);
          if (count_q == 0) head_q = s;
          else pool_link[tail_q] = s;
          tail_q = s;
          count_q++;
        end
      end
      lle_pkg::OP_POP_FRONT: begin
        if (count_q == 0) res.status = lle_pkg::ST_EMPTY;
        else begin
          s = head_q;
          res.dout = pool_word[s];
          res.valid = 1'b1;
          head_q = pool_link[s];
          free_slot(s);
          count_q--;
        end
      end
      lle_pkg::OP_POP_BACK: begin
        if (count_q == 0) res.status = lle_pkg::ST_EMPTY;
        else begin
          s = tail_q;
          res.dout = pool_word[s];
          res.valid = 1'b1;
          if (count_q >= 2) tail_q = slot_at(count_q - 2);
          free_slot(s);
          count_q--;
        end
      end
      lle_pkg::OP_INSERT: begin
        if (pos > count_q) res.status = lle_pkg::ST_EMPTY;
        else if (full) res.status = lle_pkg::ST_FULL;
        else begin
          p = slot_at(pos - 1);
          s = alloc_slot(r.word);
          pool_link[s] = pool_link[p];
          pool_link[p] = s;
          if (pos == count_q) tail_q = s;
          count_q++;
        end
      end
      lle_pkg::OP_DELETE: begin
        if (pos >= count_q) res.status = lle_pkg::ST_EMPTY;
        else if (pos == 0) begin
          s = head_q;
          head_q = pool_link[s];
          free_slot(s);
          count_q--;
          if (count_q > 0) begin
            res.dout = pool_word[head_q];
            res.valid = 1'b1;
          end
        end else begin
          p = slot_at(pos - 1);
          nd = pool_link[p];
          pool_link[p] = pool_link[nd];
          if (pos == count_q - 1) tail_q = p;
          free_slot(nd);
          count_q--;
          if (pos < count_q) begin
            res.dout = pool_word[pool_link[p]];
            res.valid = 1'b1;
          end
        end
      end
      lle_pkg::OP_READ_AT: begin
        if (pos >= count_q) res.status = lle_pkg::ST_EMPTY;
        else begin
          res.dout = pool_word[slot_at(pos)];
          res.valid = 1'b1;
        end
      end
      default: begin
        if (count_q == 0) res.status = lle_pkg::ST_EMPTY;
        else begin
          res.dout = pool_word[tail_q];
          res.valid = 1'b1;
        end
      end
    endcase
    res.len = count_q[6:0];
    return res;
  endfunction

  function automatic void add_req(lle_pkg::op_e op, int unsigned pos, logic [31:0] w);
    list_req_t r;
    r.op = op;
    r.pos = pos[6:0];
    r.word = w;
    pending_reqs.push_back(r);
  endfunction

  // request driver, no idling while requests 400 to 549 go out
  always @(posedge clk_i or negedge rst_ni) begin
    list_req_t r;
    if (!rst_ni) begin
      start_i <= 1'b0;
      op_i <= '0;
      position_i <= '0;
      data_in_i <= '0;
    end else if (!start_i || !busy_o) begin
      if (start_i) expected_resps.push_back(predict_list_op('{lle_pkg::op_e'(op_i),
                                                              position_i, data_in_i}));
      if (pending_reqs.size() > 0 &&
          ((sent >= 400 && sent < 550) || $urandom_range(99) >= 32)) begin
        r = pending_reqs.pop_front();
        sent++;
        start_i <= 1'b1;
        op_i <= r.op;
        position_i <= r.pos;
        data_in_i <= r.word;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    list_resp_t e;
    if (rst_ni && done_o) begin
      checked++;
      if (expected_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = expected_resps.pop_front();
        if (status_o !== e.status || data_valid_o !== e.valid ||
            data_out_o !== e.dout || length_o !== e.len) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d v %0d d %h len %0d, got st %0d v %0d d %h len %0d",
                     e.status, e.valid, e.dout, e.len, status_o, data_valid_o,
                     data_out_o, length_o);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int unsigned pick, fill;
    for (int i = 0; i < Cap; i++) begin
      pool_word[i] = '0;
      pool_link[i] = 6'((i + 1) % Cap);
    end
    head_q = '0; tail_q = '0; free_q = '0; count_q = 0;
    mismatches = 0; checked = 0; sent = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty cases, extremes, full pool
    add_req(lle_pkg::OP_POP_FRONT, 0, '0);
    add_req(lle_pkg::OP_POP_BACK, 0, '0);
    add_req(lle_pkg::OP_READ_BACK, 0, '0);
    add_req(lle_pkg::OP_READ_AT, 0, '0);
    add_req(lle_pkg::OP_DELETE, 0, '0);
    add_req(lle_pkg::OP_INSERT, 1, 32'h1);
    add_req(lle_pkg::OP_INSERT, 0, 32'hFFFF_FFFF);
    add_req(lle_pkg::OP_PUSH_BACK, 0, 32'h0);
    add_req(lle_pkg::OP_PUSH_FRONT, 127, 32'hA5A5_5A5A);
    add_req(lle_pkg::OP_INSERT, 3, 32'h5A5A_A5A5);
    add_req(lle_pkg::OP_READ_AT, 2, '0);
    add_req(lle_pkg::OP_DELETE, 3, '0);
    add_req(lle_pkg::OP_DELETE, 1, '0);
    add_req(lle_pkg::OP_DELETE, 0, '0);
    add_req(lle_pkg::OP_READ_BACK, 0, '0);
    add_req(lle_pkg::OP_POP_BACK, 0, '0);
    for (int i = 0; i < 65; i++) add_req(lle_pkg::OP_PUSH_BACK, 0, $urandom());
    add_req(lle_pkg::OP_INSERT, 64, 32'h7);
    add_req(lle_pkg::OP_INSERT, 65, 32'h7);
    add_req(lle_pkg::OP_PUSH_FRONT, 0, 32'h7);
    add_req(lle_pkg::OP_READ_AT, 63, '0);
    add_req(lle_pkg::OP_READ_AT, 64, '0);
    add_req(lle_pkg::OP_DELETE, 63, '0);
    add_req(lle_pkg::OP_POP_BACK, 0, '0);

    // random: mostly valid indexes, some out of range, fill and drain phases
    for (int i = 0; i < 1010; i++) begin
      pick = $urandom_range(7);
      fill = (i / 150) % 2 == 0 ? 40 : 20;
      if ($urandom_range(99) < fill) pick = $urandom_range(1) ? 1 : 4;
      if ($urandom_range(9) == 0) add_req(lle_pkg::op_e'(pick), $urandom_range(127), $urandom());
      else add_req(lle_pkg::op_e'(pick), $urandom_range(64), $urandom());
    end

    while (pending_reqs.size() != 0 || start_i) @(posedge clk_i);
    while (expected_resps.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("sent %0d list requests over all opcodes, empty and full pool, bad indexes",
             sent);
    $display("%0d results checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && expected_resps.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
